>>> rtl/pwmix_pkg.sv
// ----------------------------------------------------------------------------
// pwmix_pkg
// Item formats, action codes and fixed constants of the wavetable mixer.
// ----------------------------------------------------------------------------
package pwmix_pkg;

    localparam int GAIN_W = 4;
    localparam logic [GAIN_W-1:0] GAIN_RESET = 4'd12;

    localparam int MIX_W  = 12;
    localparam int DAC_W  = 16;
    localparam int MASK_W = 12;

    localparam int MIX_MAX = 4095;
    localparam int DAC_MAX = 65535;

    localparam logic [1:0] ACT_TICK   = 2'd0;
    localparam logic [1:0] ACT_TOGGLE = 2'd1;
    localparam logic [1:0] ACT_SAMPLE = 2'd2;
    localparam logic [1:0] ACT_LENGTH = 2'd3;

    typedef struct packed {
        logic [1:0]  action;
        logic [3:0]  voice;
        logic [9:0]  sample_addr;
        logic [10:0] load_value;
    } in_item_t;

    typedef struct packed {
        logic [MIX_W-1:0]  mix_sum;
        logic [DAC_W-1:0]  dac_word;
        logic [MASK_W-1:0] active_mask;
    } out_item_t;

endpackage

>>> rtl/pwmix_wave_mem.sv
// ----------------------------------------------------------------------------
// pwmix_wave_mem
// Wave sample store for all voices: one write port, one registered read port.
// ----------------------------------------------------------------------------
module pwmix_wave_mem #(
    parameter int DEPTH  = 12288,
    parameter int DATA_W = 8,
    parameter int ADDR_W = 14
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/pwmix_voice_mem.sv
// ----------------------------------------------------------------------------
// pwmix_voice_mem
// Per-voice phase and table length store. A phase that has not been written
// since reset reads as zero.
// ----------------------------------------------------------------------------
module pwmix_voice_mem #(
    parameter int VOICES = 12,
    parameter int PH_W   = 10,
    parameter int LEN_W  = 11,
    parameter int VI_W   = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             we,
    input  logic [VI_W-1:0]  waddr,
    input  logic [PH_W-1:0]  wphase,
    input  logic [LEN_W-1:0] wlen,
    input  logic [VI_W-1:0]  raddr,
    output logic [PH_W-1:0]  rphase,
    output logic [LEN_W-1:0] rlen
);

    logic [PH_W+LEN_W-1:0] mem [VOICES];
    logic [PH_W+LEN_W-1:0] rdata_reg;
    logic [VOICES-1:0]     written_reg;
    logic                  rd_ok_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= {wphase, wlen};
        end
        rdata_reg <= mem[raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            written_reg <= '0;
            rd_ok_reg   <= 1'b0;
        end
        else
        begin
            if (we)
            begin
                written_reg[waddr] <= 1'b1;
            end
            rd_ok_reg <= written_reg[raddr];
        end
    end

    assign rphase = rd_ok_reg ? rdata_reg[PH_W+LEN_W-1:LEN_W] : '0;
    assign rlen   = rdata_reg[LEN_W-1:0];

endmodule

>>> rtl/pwmix_out_stage.sv
// ----------------------------------------------------------------------------
// pwmix_out_stage
// Scales the mixed sum by the gain, saturates both fields and holds the
// result beat until the receiver takes it.
// ----------------------------------------------------------------------------
module pwmix_out_stage #(
    parameter int SUM_W = 12
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                load,
    input  logic [SUM_W-1:0]                    sum,
    input  logic [pwmix_pkg::GAIN_W-1:0]        gain,
    input  logic [pwmix_pkg::MASK_W-1:0]        mask,
    output logic                                free,
    output logic                                out_valid,
    input  logic                                out_stall,
    output pwmix_pkg::out_item_t                out_data
);

    import pwmix_pkg::*;

    localparam int PROD_W = SUM_W + GAIN_W;

    logic [PROD_W-1:0] prod;
    out_item_t         item_next;
    out_item_t         item_reg;
    logic              valid_reg;

    always_comb
    begin
        prod = PROD_W'(sum) * PROD_W'(gain);
        item_next.mix_sum     = (32'(sum) > MIX_MAX) ? MIX_W'(MIX_MAX) : MIX_W'(sum);
        item_next.dac_word    = (32'(prod) > DAC_MAX) ? DAC_W'(DAC_MAX) : DAC_W'(prod);
        item_next.active_mask = mask;
    end

    assign free = !valid_reg || !out_stall;

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= item_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            valid_reg <= 1'b0;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = item_reg;

endmodule

>>> rtl/polyphonic_wavetable_mixer_core.sv
// ----------------------------------------------------------------------------
// polyphonic_wavetable_mixer_core
// Wavetable oscillator bank: per-voice phase, length and on flag, a summing
// mixer and a saturating gain stage.
// ----------------------------------------------------------------------------
// The sequencer walks the voices one per cycle through the voice memory and
// then the wave memory, each a registered read. The sweep ends once the
// pipeline is empty, and a finish state then hands the sum to the gain stage.
// That hand-off waits for as long as the previous result is still held at
// the output. A length write reads the voice entry and then writes it back
// in a separate length state; toggle and sample writes need no second state.
// A new beat is taken once the previous one is finished, while an earlier
// result may still wait at the output. Lengths of all voices must be loaded
// before the first tick; there is no clearing pass after reset.
module polyphonic_wavetable_mixer_core #(
    parameter int VOICES      = 12,
    parameter int TABLE_DEPTH = 1024,
    parameter int SAMPLE_BITS = 8
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  pwmix_pkg::in_item_t            in_data,
    output logic                           out_valid,
    input  logic                           out_stall,
    output pwmix_pkg::out_item_t           out_data,
    input  logic                           cfg_we,
    input  logic [pwmix_pkg::GAIN_W-1:0]   cfg_data
);

    import pwmix_pkg::*;

    localparam int PH_W  = $clog2(TABLE_DEPTH);
    localparam int NX_W  = PH_W + 1;
    localparam int LEN_W = $clog2(TABLE_DEPTH + 1);
    localparam int VI_W  = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam int VC_W  = $clog2(VOICES + 1);
    localparam int WA_W  = $clog2(VOICES * TABLE_DEPTH);
    localparam int SUM_W = $clog2(VOICES * ((1 << SAMPLE_BITS) - 1) + 1);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_LEN    = 4'b0010,
        ST_SWEEP  = 4'b0100,
        ST_FINISH = 4'b1000
    } state_t;

    state_t             state_reg, state_next;
    logic [GAIN_W-1:0]  gain_reg;
    logic [VOICES-1:0]  voice_on_reg;
    logic [VC_W-1:0]    iss_cnt_reg;
    logic               p1_vld_reg, p2_vld_reg, p2_on_reg;
    logic [VI_W-1:0]    p1_idx_reg;
    logic [SUM_W-1:0]   acc_reg;
    logic [VI_W-1:0]    len_idx_reg;
    logic [LEN_W-1:0]   len_reg;

    logic               in_acc, voice_ok, addr_ok, iss_go, out_free, p1_on;
    logic [LEN_W-1:0]   len_clamped;
    logic [MASK_W-1:0]  mask;

    logic               vm_we;
    logic [VI_W-1:0]    vm_waddr, vm_raddr;
    logic [PH_W-1:0]    vm_wphase, vm_rphase;
    logic [LEN_W-1:0]   vm_wlen, vm_rlen;
    logic [NX_W-1:0]    nxt_sum;

    logic                   wm_we;
    logic [WA_W-1:0]        wm_waddr, wm_raddr;
    logic [SAMPLE_BITS-1:0] wm_rdata;

    assign in_stall = (state_reg != ST_IDLE);
    assign in_acc   = in_valid && !in_stall;
    assign voice_ok = 32'(in_data.voice) < VOICES;
    assign addr_ok  = 32'(in_data.sample_addr) < TABLE_DEPTH;
    assign iss_go   = (state_reg == ST_SWEEP) && (32'(iss_cnt_reg) < VOICES);
    assign p1_on    = voice_on_reg[p1_idx_reg];

    always_comb
    begin
        if (in_data.load_value == '0)
        begin
            len_clamped = LEN_W'(1);
        end
        else if (32'(in_data.load_value) > TABLE_DEPTH)
        begin
            len_clamped = LEN_W'(TABLE_DEPTH);
        end
        else
        begin
            len_clamped = LEN_W'(in_data.load_value);
        end
    end

    // Only the first twelve voices have a place in the mask.
    genvar gi;
    generate
        for (gi = 0; gi < MASK_W; gi++)
        begin : g_mask
            if (gi < VOICES)
            begin : g_on
                assign mask[gi] = voice_on_reg[gi];
            end
            else
            begin : g_off
                assign mask[gi] = 1'b0;
            end
        end
    endgenerate

    // Voice memory: the sweep reads voice k while it writes back voice k-1,
    // so the two never touch the same entry.
    always_comb
    begin
        nxt_sum   = NX_W'(vm_rphase) + NX_W'(p1_on);
        vm_raddr  = (state_reg == ST_IDLE) ? VI_W'(in_data.voice)
                                           : iss_cnt_reg[VI_W-1:0];
        vm_we     = 1'b0;
        vm_waddr  = p1_idx_reg;
        vm_wphase = (nxt_sum >= NX_W'(vm_rlen)) ? '0 : PH_W'(nxt_sum);
        vm_wlen   = vm_rlen;
        if (state_reg == ST_LEN)
        begin
            vm_we     = 1'b1;
            vm_waddr  = len_idx_reg;
            vm_wphase = vm_rphase;
            vm_wlen   = len_reg;
        end
        else if (state_reg == ST_SWEEP)
        begin
            vm_we = p1_vld_reg;
        end
    end

    assign wm_we    = in_acc && (in_data.action == ACT_SAMPLE) && voice_ok && addr_ok;
    assign wm_waddr = WA_W'(in_data.voice) * WA_W'(TABLE_DEPTH)
                    + WA_W'(in_data.sample_addr);
    assign wm_raddr = WA_W'(p1_idx_reg) * WA_W'(TABLE_DEPTH) + WA_W'(vm_rphase);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc && (in_data.action == ACT_TICK))
                begin
                    state_next = ST_SWEEP;
                end
                else if (in_acc && (in_data.action == ACT_LENGTH) && voice_ok)
                begin
                    state_next = ST_LEN;
                end
            end
            ST_LEN:
            begin
                state_next = ST_IDLE;
            end
            ST_SWEEP:
            begin
                if (!iss_go && !p1_vld_reg && !p2_vld_reg)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            gain_reg     <= GAIN_RESET;
            voice_on_reg <= VOICES'(1);
            iss_cnt_reg  <= '0;
            p1_vld_reg   <= 1'b0;
            p2_vld_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            p1_vld_reg <= iss_go;
            p2_vld_reg <= p1_vld_reg;
            if (cfg_we)
            begin
                gain_reg <= cfg_data;
            end
            if (in_acc && (in_data.action == ACT_TOGGLE) && voice_ok)
            begin
                voice_on_reg[VI_W'(in_data.voice)] <= !voice_on_reg[VI_W'(in_data.voice)];
            end
            if (in_acc && (in_data.action == ACT_TICK))
            begin
                iss_cnt_reg <= '0;
            end
            else if (iss_go)
            begin
                iss_cnt_reg <= iss_cnt_reg + VC_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        p1_idx_reg <= iss_cnt_reg[VI_W-1:0];
        p2_on_reg  <= p1_on;
        if (in_acc)
        begin
            len_idx_reg <= VI_W'(in_data.voice);
            len_reg     <= len_clamped;
        end
        if (in_acc && (in_data.action == ACT_TICK))
        begin
            acc_reg <= '0;
        end
        else if (p2_vld_reg && p2_on_reg)
        begin
            acc_reg <= acc_reg + SUM_W'(wm_rdata);
        end
    end

    pwmix_voice_mem #(
        .VOICES (VOICES),
        .PH_W   (PH_W),
        .LEN_W  (LEN_W),
        .VI_W   (VI_W)
    ) u_voice_mem (
        .clk    (clk),
        .rst_n  (rst_n),
        .we     (vm_we),
        .waddr  (vm_waddr),
        .wphase (vm_wphase),
        .wlen   (vm_wlen),
        .raddr  (vm_raddr),
        .rphase (vm_rphase),
        .rlen   (vm_rlen)
    );

    pwmix_wave_mem #(
        .DEPTH  (VOICES * TABLE_DEPTH),
        .DATA_W (SAMPLE_BITS),
        .ADDR_W (WA_W)
    ) u_wave_mem (
        .clk   (clk),
        .we    (wm_we),
        .waddr (wm_waddr),
        .wdata (SAMPLE_BITS'(in_data.load_value)),
        .raddr (wm_raddr),
        .rdata (wm_rdata)
    );

    pwmix_out_stage #(
        .SUM_W (SUM_W)
    ) u_out_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      ((state_reg == ST_FINISH) && out_free),
        .sum       (acc_reg),
        .gain      (gain_reg),
        .mask      (mask),
        .free      (out_free),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the wavetable mixer core. Beats are generated into
// a queue, the expected mix of every tick is worked out from a behavioral
// copy of the voice bank, and each result beat is compared field by field.
// ----------------------------------------------------------------------------
module tb_top;

    import pwmix_pkg::*;

    localparam int VOICE_N     = 12;
    localparam int TABLE_N     = 1024;
    localparam int PHASES      = 6;
    localparam int PHASE_BEATS = 175;
    localparam int IDLE_PCT    = 36;
    localparam int HOLD_AT     = 40;
    localparam int HOLD_CYCLES = 300;
    localparam int SETTLE      = 24;
    localparam int QUIET_LIMIT = 4000;

    typedef struct {
        in_item_t  beat;
        bit        has_mix;
        out_item_t mix;
    } pend_t;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_stall;
    in_item_t  in_data = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    out_item_t out_data;
    logic      cfg_we = 1'b0;
    logic [GAIN_W-1:0] cfg_data = '0;

    // Behavioral copy of the voice bank.
    logic [GAIN_W-1:0] gain_now;
    bit                sounding [VOICE_N];
    logic [9:0]        phase_pos [VOICE_N];
    logic [10:0]       tbl_len [VOICE_N];
    logic [7:0]        wave_mem [VOICE_N*TABLE_N];
    bit                wave_set [VOICE_N*TABLE_N];

    pend_t     beat_q [$];
    out_item_t mix_q [$];
    pend_t     on_bus;
    out_item_t want;

    int  queued_n = 0;
    int  taken_n = 0;
    int  results_n = 0;
    int  errors = 0;
    int  hold_left = 0;
    int  quiet_n = 0;
    bit  held = 1'b0;
    bit  steady = 1'b0;

    int dir_len [VOICE_N] = '{5, 0, 1, 1024, 2047, 1025, 3, 7, 16, 31, 2, 9};

    polyphonic_wavetable_mixer_core #(
        .VOICES      (VOICE_N),
        .TABLE_DEPTH (TABLE_N),
        .SAMPLE_BITS (8)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    task automatic flag_error(input string what);
        $display("tb_top: mismatch: %s", what);
        errors++;
    endtask

    function automatic void bank_reset();
        gain_now = GAIN_RESET;
        for (int v = 0; v < VOICE_N; v++)
        begin
            sounding[v]  = (v == 0);
            phase_pos[v] = '0;
            tbl_len[v]   = '0;
        end
        for (int i = 0; i < VOICE_N*TABLE_N; i++)
        begin
            wave_mem[i] = '0;
            wave_set[i] = 1'b0;
        end
    endfunction

    // Applies one beat to the bank copy; a tick yields the mix it must produce.
    function automatic void synth_predict(input in_item_t b, output bit has_mix,
                                          output out_item_t mix);
        int sum;
        int nxt;
        int dac;
        int len;
        logic [MASK_W-1:0] mask;
        has_mix = 1'b0;
        mix = '0;
        if (b.action == ACT_TICK)
        begin
            sum = 0;
            mask = '0;
            for (int v = 0; v < VOICE_N; v++)
            begin
                if (sounding[v])
                begin
                    sum += wave_mem[v*TABLE_N + phase_pos[v]];
                    mask[v] = 1'b1;
                end
                nxt = int'(phase_pos[v]) + (sounding[v] ? 1 : 0);
                if (nxt >= tbl_len[v])
                    nxt = 0;
                phase_pos[v] = 10'(nxt);
            end
            dac = sum * gain_now;
            has_mix = 1'b1;
            mix.mix_sum = (sum > MIX_MAX) ? MIX_MAX[MIX_W-1:0] : sum[MIX_W-1:0];
            mix.dac_word = (dac > DAC_MAX) ? DAC_MAX[DAC_W-1:0] : dac[DAC_W-1:0];
            mix.active_mask = mask;
        end
        else if (b.voice < VOICE_N)
        begin
            if (b.action == ACT_TOGGLE)
                sounding[b.voice] = !sounding[b.voice];
            else if (b.action == ACT_SAMPLE)
                wave_mem[b.voice*TABLE_N + b.sample_addr] = b.load_value[7:0];
            else
            begin
                len = b.load_value;
                if (len == 0)
                    len = 1;
                if (len > TABLE_N)
                    len = TABLE_N;
                tbl_len[b.voice] = 11'(len);
            end
        end
    endfunction

    task automatic push_beat(input in_item_t b);
        pend_t p;
        p.beat = b;
        synth_predict(b, p.has_mix, p.mix);
        if (b.action == ACT_SAMPLE && b.voice < VOICE_N)
            wave_set[b.voice*TABLE_N + b.sample_addr] = 1'b1;
        beat_q.push_back(p);
        queued_n++;
    endtask

    // Every sounding voice must read a sample that was loaded; fill any hole
    // at the current phase before the tick goes out.
    task automatic push_tick(input in_item_t b);
        in_item_t fill;
        for (int v = 0; v < VOICE_N; v++)
        begin
            if (sounding[v] && !wave_set[v*TABLE_N + phase_pos[v]])
            begin
                fill.action = ACT_SAMPLE;
                fill.voice = 4'(v);
                fill.sample_addr = phase_pos[v];
                fill.load_value = 11'($urandom);
                push_beat(fill);
            end
        end
        b.action = ACT_TICK;
        push_beat(b);
    endtask

    task automatic put(input logic [1:0] act, input int v, input int addr, input int val);
        in_item_t b;
        b.action = act;
        b.voice = 4'(v);
        b.sample_addr = 10'(addr);
        b.load_value = 11'(val);
        if (act == ACT_TICK)
            push_tick(b);
        else
            push_beat(b);
    endtask

    task automatic directed_beats();
        for (int v = 0; v < VOICE_N; v++)
            put(ACT_LENGTH, v, 0, dir_len[v]);
        put(ACT_SAMPLE, 0, 0, 255);
        put(ACT_SAMPLE, 3, TABLE_N - 1, 2047);
        put(ACT_TICK, 0, 0, 0);
        put(ACT_TOGGLE, 3, 0, 0);
        put(ACT_TOGGLE, 11, 0, 0);
        put(ACT_TICK, 15, 1023, 2047);
        put(ACT_TICK, 0, 0, 0);
        put(ACT_TOGGLE, 0, 0, 0);
        // Table shrinks under a sounding voice whose phase is past the new end.
        put(ACT_LENGTH, 3, 0, 1);
        put(ACT_TICK, 0, 0, 0);
        // Same for a silent voice: its phase must still fall back to zero.
        put(ACT_TOGGLE, 11, 0, 0);
        put(ACT_LENGTH, 11, 0, 2);
        put(ACT_TICK, 0, 0, 0);
        put(ACT_TOGGLE, 0, 0, 0);
        put(ACT_TOGGLE, 13, 0, 0);
        put(ACT_LENGTH, 15, 0, 4);
        put(ACT_SAMPLE, 12, 5, 77);
    endtask

    task automatic random_beat();
        int pick;
        int lpick;
        in_item_t b;
        pick = $urandom_range(99);
        b.voice = 4'($urandom_range(VOICE_N - 1));
        b.sample_addr = 10'($urandom);
        b.load_value = 11'($urandom);
        if (pick < 45)
        begin
            b.voice = 4'($urandom);
            push_tick(b);
        end
        else if (pick < 60)
        begin
            b.action = ACT_TOGGLE;
            push_beat(b);
        end
        else if (pick < 83)
        begin
            b.action = ACT_SAMPLE;
            if ($urandom_range(99) < 70)
                b.sample_addr = 10'($urandom_range(63));
            push_beat(b);
        end
        else if (pick < 95)
        begin
            // Mostly short tables, now and then a long one or a zero length.
            b.action = ACT_LENGTH;
            lpick = $urandom_range(99);
            if (lpick < 70)
                b.load_value = 11'($urandom_range(48, 1));
            else if (lpick < 80)
                b.load_value = '0;
            else
                b.load_value = 11'($urandom_range(2047, 900));
            push_beat(b);
        end
        else
        begin
            b.action = 2'($urandom_range(3, 1));
            b.voice = 4'($urandom_range(15, VOICE_N));
            push_beat(b);
        end
    endtask

    task automatic drain();
        while (taken_n != queued_n || mix_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_gain(input logic [GAIN_W-1:0] g);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_data <= g;
        @(posedge clk);
        cfg_we <= 1'b0;
        gain_now = g;
    endtask

    initial
    begin
        logic [GAIN_W-1:0] g;
        bank_reset();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        for (int ph = 0; ph < PHASES; ph++)
        begin
            if (ph > 0)
            begin
                drain();
                case (ph)
                    1: g = 4'd15;
                    2: g = 4'd0;
                    4: g = 4'd1;
                    default: g = 4'($urandom_range(14, 2));
                endcase
                write_gain(g);
            end
            steady = (ph == 3);
            if (ph == 0)
                directed_beats();
            while (queued_n < (ph + 1) * PHASE_BEATS)
                random_beat();
        end
        drain();
        if (mix_q.size() != 0)
            flag_error($sformatf("%0d results never arrived", mix_q.size()));
        if (errors == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

    // Sender: a new beat is offered only once the bus is free.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                if (on_bus.has_mix)
                    mix_q.push_back(on_bus.mix);
                taken_n++;
            end
            if (!in_valid || !in_stall)
            begin
                if (beat_q.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT))
                begin
                    on_bus = beat_q.pop_front();
                    in_data <= on_bus.beat;
                    in_valid <= 1'b1;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Receiver and checker.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                results_n++;
                if (mix_q.size() == 0)
                    flag_error($sformatf("unexpected result beat, mix_sum %0d",
                                         out_data.mix_sum));
                else
                begin
                    want = mix_q.pop_front();
                    if (out_data.mix_sum !== want.mix_sum)
                        flag_error($sformatf("result %0d mix_sum %0d, expected %0d",
                                             results_n, out_data.mix_sum, want.mix_sum));
                    if (out_data.dac_word !== want.dac_word)
                        flag_error($sformatf("result %0d dac_word %0d, expected %0d",
                                             results_n, out_data.dac_word, want.dac_word));
                    if (out_data.active_mask !== want.active_mask)
                        flag_error($sformatf("result %0d active_mask %h, expected %h",
                                             results_n, out_data.active_mask,
                                             want.active_mask));
                end
            end
            // One long hold-off so the core backs up and stalls its input.
            if (results_n == HOLD_AT && !held)
            begin
                held = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= !steady && ($urandom_range(99) < IDLE_PCT);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_n = 0;
            else
                quiet_n++;
            if (quiet_n >= QUIET_LIMIT)
            begin
                $display("tb_top: done, errors");
                $finish;
            end
        end
    end

endmodule

>>> polyphonic_wavetable_mixer_core.f
rtl/pwmix_pkg.sv
rtl/pwmix_wave_mem.sv
rtl/pwmix_voice_mem.sv
rtl/pwmix_out_stage.sv
rtl/polyphonic_wavetable_mixer_core.sv
tb/tb_top.sv
